// File: rtl/rv32i_execute_step_assert.svh
// assertion macros for the execute step
// used by rv32i_execute_step.sv
`ifndef RV32I_EXECUTE_STEP_ASSERT_SVH
`define RV32I_EXECUTE_STEP_ASSERT_SVH
`ifndef SYNTH
`define CHK_IMPL(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("%m failed");
`define CHK_NEXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("%m failed");
`else
`define CHK_IMPL(lbl, a, c)
`define CHK_NEXT(lbl, a, c)
`endif
`endif

// File: rtl/rv32x_pkg.sv
// shared types and opcodes for the execute step
// no dependencies
package rv32x_pkg;
  localparam logic [5:0] OP_ADDI = 6'd0, OP_ANDI = 6'd1, OP_JALR = 6'd2, OP_LB = 6'd3,
    OP_LBU = 6'd4, OP_LH = 6'd5, OP_LHU = 6'd6, OP_LW = 6'd7, OP_ORI = 6'd8,
    OP_SLLI = 6'd9, OP_SLTI = 6'd10, OP_SLTIU = 6'd11, OP_SRAI = 6'd12, OP_SRLI = 6'd13,
    OP_XORI = 6'd14, OP_SB = 6'd15, OP_SH = 6'd16, OP_SW = 6'd17, OP_ADD = 6'd18,
    OP_AND = 6'd19, OP_OR = 6'd20, OP_SLL = 6'd21, OP_SLT = 6'd22, OP_SLTU = 6'd23,
    OP_SRA = 6'd24, OP_SRL = 6'd25, OP_SUB = 6'd26, OP_XOR = 6'd27, OP_BEQ = 6'd28,
    OP_BGE = 6'd29, OP_BGEU = 6'd30, OP_BLT = 6'd31, OP_BLTU = 6'd32, OP_BNE = 6'd33,
    OP_JAL = 6'd34, OP_AUIPC = 6'd35, OP_LUI = 6'd36;
  typedef enum logic [1:0] {ST_INIT, ST_READ, ST_EXEC, ST_LOAD} state_t;
endpackage

// File: rtl/rv32i_execute_step.sv
//  channel | valid     | stall     | fields
//  in      | in_valid  | in_stall  | op rd rs1 rs2 imm
//  out     | out_valid | out_stall | next_pc reg_written dest_index dest_value bad_op
// an instruction does the register file read, then execute and write back;
// loads then pass ST_LOAD for the byte memory read port
// after reset a clearing pass zeroes the memory
// and loads the register file, no word taken
// a stalled result holds and the next word waits until the output register frees
// reset is synchronous, active high
`include "rv32i_execute_step_assert.svh"
module rv32i_execute_step #(
  parameter int MEM_BYTES = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [5:0]         op,
  input  logic [4:0]         rd,
  input  logic [4:0]         rs1,
  input  logic [4:0]         rs2,
  input  logic signed [31:0] imm,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] next_pc,
  output logic               reg_written,
  output logic [4:0]         dest_index,
  output logic [31:0]        dest_value,
  output logic               bad_op
);
  localparam int AW = $clog2(MEM_BYTES);
  localparam int LW = AW - 2;
  localparam int LINES = MEM_BYTES / 4;
  localparam int CLR_LEN = (LINES > 32) ? LINES : 32;
  localparam int CW = $clog2(CLR_LEN) + 1;

  rv32x_pkg::state_t state, state_next;
  logic [31:0] rf_a [32];
  logic [31:0] rf_b [32];
  logic [7:0]  mem0 [LINES];
  logic [7:0]  mem1 [LINES];
  logic [7:0]  mem2 [LINES];
  logic [7:0]  mem3 [LINES];
  logic [CW-1:0] clr_cnt;
  logic [31:0] pc;
  logic [31:0] a_q, b_q;
  logic [5:0]  op_q;
  logic [4:0]  rd_q;
  logic [31:0] imm_q;
  logic [7:0]  rb [4];
  logic [1:0]  lo_q;
  logic [31:0] addr;
  logic [AW-1:0] bidx [4];
  logic [31:0] val, npc, ldv, stv;
  logic        wr, bad, take, is_ld, is_st, fire_out, accept;
  logic [2:0]  nbytes;
  logic [4:0]  sh;

  assign in_stall = (state != rv32x_pkg::ST_READ) || (out_valid && out_stall);
  assign accept = in_valid && !in_stall;
  assign fire_out = (state == rv32x_pkg::ST_EXEC && !is_ld) || state == rv32x_pkg::ST_LOAD;

  // byte addresses of the access, each wrapped to the memory
  assign addr = a_q + imm_q;
  always_comb begin
    for (int i = 0; i < 4; i++) bidx[i] = AW'(addr + 32'(i));
  end
  assign is_ld = op_q >= rv32x_pkg::OP_LB && op_q <= rv32x_pkg::OP_LW;
  assign is_st = op_q >= rv32x_pkg::OP_SB && op_q <= rv32x_pkg::OP_SW;
  assign nbytes = (op_q == rv32x_pkg::OP_SW || op_q == rv32x_pkg::OP_LW) ? 3'd4 :
    (op_q == rv32x_pkg::OP_SH || op_q == rv32x_pkg::OP_LH || op_q == rv32x_pkg::OP_LHU)
    ? 3'd2 : 3'd1;

  // load data reassembled from the four byte lanes
  always_comb begin
    logic [7:0] by [4];
    for (int i = 0; i < 4; i++) by[i] = rb[2'(lo_q + 2'(i))];
    unique case (op_q)
      rv32x_pkg::OP_LB:  ldv = {{24{by[0][7]}}, by[0]};
      rv32x_pkg::OP_LBU: ldv = {24'd0, by[0]};
      rv32x_pkg::OP_LH:  ldv = {{16{by[1][7]}}, by[1], by[0]};
      rv32x_pkg::OP_LHU: ldv = {16'd0, by[1], by[0]};
      default:           ldv = {by[3], by[2], by[1], by[0]};
    endcase
  end

  // execute
  assign sh = (op_q >= rv32x_pkg::OP_ADD) ? b_q[4:0] : imm_q[4:0];
  assign stv = b_q;
  always_comb begin
    val = 32'd0; wr = 1'b1; bad = 1'b0; take = 1'b0;
    npc = pc + 32'd4;
    case (op_q)
      rv32x_pkg::OP_ADDI:  val = a_q + imm_q;
      rv32x_pkg::OP_ANDI:  val = a_q & imm_q;
      rv32x_pkg::OP_JALR:  begin val = pc + 32'd4; npc = addr & ~32'd1; end
      rv32x_pkg::OP_ORI:   val = a_q | imm_q;
      rv32x_pkg::OP_SLLI, rv32x_pkg::OP_SLL: val = a_q << sh;
      rv32x_pkg::OP_SLTI:  val = {31'd0, $signed(a_q) < $signed(imm_q)};
      rv32x_pkg::OP_SLTIU: val = {31'd0, a_q < imm_q};
      rv32x_pkg::OP_SRAI, rv32x_pkg::OP_SRA: val = 32'($signed(a_q) >>> sh);
      rv32x_pkg::OP_SRLI, rv32x_pkg::OP_SRL: val = a_q >> sh;
      rv32x_pkg::OP_XORI:  val = a_q ^ imm_q;
      rv32x_pkg::OP_ADD:   val = a_q + b_q;
      rv32x_pkg::OP_AND:   val = a_q & b_q;
      rv32x_pkg::OP_OR:    val = a_q | b_q;
      rv32x_pkg::OP_SLT:   val = {31'd0, $signed(a_q) < $signed(b_q)};
      rv32x_pkg::OP_SLTU:  val = {31'd0, a_q < b_q};
      rv32x_pkg::OP_SUB:   val = a_q - b_q;
      rv32x_pkg::OP_XOR:   val = a_q ^ b_q;
      rv32x_pkg::OP_BEQ:   begin wr = 1'b0; take = a_q == b_q; end
      rv32x_pkg::OP_BGE:   begin wr = 1'b0; take = $signed(a_q) >= $signed(b_q); end
      rv32x_pkg::OP_BGEU:  begin wr = 1'b0; take = a_q >= b_q; end
      rv32x_pkg::OP_BLT:   begin wr = 1'b0; take = $signed(a_q) < $signed(b_q); end
      rv32x_pkg::OP_BLTU:  begin wr = 1'b0; take = a_q < b_q; end
      rv32x_pkg::OP_BNE:   begin wr = 1'b0; take = a_q != b_q; end
      rv32x_pkg::OP_JAL:   begin val = pc + 32'd4; npc = pc + imm_q; end
      rv32x_pkg::OP_AUIPC: val = pc + {imm_q[19:0], 12'd0};
      rv32x_pkg::OP_LUI:   val = {imm_q[19:0], 12'd0};
      default: begin
        if (is_ld) val = ldv;
        else if (is_st) wr = 1'b0;
        else begin wr = 1'b0; bad = 1'b1; end
      end
    endcase
    if (take) npc = pc + imm_q;
    if (rd_q == 5'd0) wr = 1'b0;
  end

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      rv32x_pkg::ST_INIT: if (clr_cnt == CW'(CLR_LEN - 1)) state_next = rv32x_pkg::ST_READ;
      rv32x_pkg::ST_READ: if (accept) state_next = rv32x_pkg::ST_EXEC;
      rv32x_pkg::ST_EXEC: state_next = is_ld ? rv32x_pkg::ST_LOAD : rv32x_pkg::ST_READ;
      rv32x_pkg::ST_LOAD: state_next = rv32x_pkg::ST_READ;
      default:            state_next = rv32x_pkg::ST_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rv32x_pkg::ST_INIT;
      clr_cnt <= '0;
      pc <= 32'd0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == rv32x_pkg::ST_INIT) clr_cnt <= clr_cnt + 1'b1;
      if (fire_out) begin
        pc <= npc;
        out_valid <= 1'b1;
      end else if (!out_stall) out_valid <= 1'b0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (fire_out) begin
      next_pc <= npc;
      reg_written <= wr;
      dest_index <= wr ? rd_q : 5'd0;
      dest_value <= wr ? val : 32'd0;
      bad_op <= bad;
    end
  end

  // register file, two read copies, reset image written during the clearing pass
  always_ff @(posedge clk) begin
    if (state == rv32x_pkg::ST_INIT && clr_cnt < CW'(32)) begin
      rf_a[5'(clr_cnt)] <= (clr_cnt == CW'(2)) ? 32'(MEM_BYTES) : 32'd0;
      rf_b[5'(clr_cnt)] <= (clr_cnt == CW'(2)) ? 32'(MEM_BYTES) : 32'd0;
    end else if (fire_out && wr) begin
      rf_a[rd_q] <= val;
      rf_b[rd_q] <= val;
    end
    if (accept) begin
      a_q <= (rs1 == 5'd0) ? 32'd0 : rf_a[rs1];
      b_q <= (rs2 == 5'd0) ? 32'd0 : rf_b[rs2];
      op_q <= op;
      rd_q <= rd;
      imm_q <= imm;
    end
  end

  // byte memory in four lanes, one byte per lane per access
  always_ff @(posedge clk) begin
    if (state == rv32x_pkg::ST_INIT) begin
      if (clr_cnt < CW'(LINES)) begin
        mem0[LW'(clr_cnt)] <= 8'd0;
        mem1[LW'(clr_cnt)] <= 8'd0;
        mem2[LW'(clr_cnt)] <= 8'd0;
        mem3[LW'(clr_cnt)] <= 8'd0;
      end
    end else if (state == rv32x_pkg::ST_EXEC && is_st) begin
      for (int i = 0; i < 4; i++) begin
        if (3'(i) < nbytes) begin
          unique case (bidx[i][1:0])
            2'd0: mem0[bidx[i][AW-1:2]] <= stv[8*i +: 8];
            2'd1: mem1[bidx[i][AW-1:2]] <= stv[8*i +: 8];
            2'd2: mem2[bidx[i][AW-1:2]] <= stv[8*i +: 8];
            default: mem3[bidx[i][AW-1:2]] <= stv[8*i +: 8];
          endcase
        end
      end
    end
    // lanes below the start lane come from the next line
    rb[0] <= mem0[(bidx[0][1:0] == 2'd0 ? bidx[0][AW-1:2] : bidx[0][AW-1:2] + LW'(1))];
    rb[1] <= mem1[(bidx[0][1:0] <= 2'd1 ? bidx[0][AW-1:2] : bidx[0][AW-1:2] + LW'(1))];
    rb[2] <= mem2[(bidx[0][1:0] <= 2'd2 ? bidx[0][AW-1:2] : bidx[0][AW-1:2] + LW'(1))];
    rb[3] <= mem3[bidx[0][AW-1:2]];
    lo_q <= bidx[0][1:0];
  end

  `CHK_IMPL(a_no_accept_busy, state != rv32x_pkg::ST_READ, !accept)
  `CHK_NEXT(a_exec_after_accept, accept, state == rv32x_pkg::ST_EXEC)
  `CHK_IMPL(a_no_x0_write, out_valid && reg_written, dest_index != 5'd0)
  `CHK_IMPL(a_bad_no_write, out_valid && bad_op, !reg_written)
endmodule

// File: tb/rv32i_execute_step_test.sv
// self-checking testbench for rv32i_execute_step: directed and random instruction words,
// predicted against a behavioral copy of registers, pc and byte memory
// depends on rv32x_pkg and the rv32i_execute_step rtl
module rv32i_execute_step_test;

  localparam int MEM_BYTES = 1024;
  localparam int N_RANDOM = 1525;

  typedef struct {
    logic [5:0]  op;
    logic [4:0]  rd;
    logic [4:0]  rs1;
    logic [4:0]  rs2;
    logic [31:0] imm;
    bit          hold;
  } instr_t;

  typedef struct {
    logic [31:0] next_pc;
    logic        reg_written;
    logic [4:0]  dest_index;
    logic [31:0] dest_value;
    logic        bad_op;
  } commit_t;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  logic [5:0] op = '0;
  logic [4:0] rd = '0;
  logic [4:0] rs1 = '0;
  logic [4:0] rs2 = '0;
  logic signed [31:0] imm = '0;
  logic out_valid;
  logic out_stall = 0;
  logic signed [31:0] next_pc;
  logic reg_written;
  logic [4:0] dest_index;
  logic [31:0] dest_value;
  logic bad_op;

  instr_t  pending_words[$];
  commit_t expected_commits[$];
  int      n_errors = 0;
  int      n_sent = 0;
  bit      feeding_done = 0;

  // shadow architectural state
  logic [31:0] arch_regs[32];
  logic [31:0] arch_pc;
  logic [7:0]  arch_mem[MEM_BYTES];

  rv32i_execute_step #(.MEM_BYTES(MEM_BYTES)) i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .op(op), .rd(rd), .rs1(rs1), .rs2(rs2), .imm(imm),
    .out_valid(out_valid), .out_stall(out_stall),
    .next_pc(next_pc), .reg_written(reg_written), .dest_index(dest_index),
    .dest_value(dest_value), .bad_op(bad_op)
  );

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  function automatic logic [31:0] load_bytes(input logic [31:0] addr, input int n);
    logic [31:0] v;
    logic [31:0] a;
    v = '0;
    for (int i = 0; i < n; i++) begin
      a = addr + i;
      v |= 32'(arch_mem[a % MEM_BYTES]) << (8 * i);
    end
    return v;
  endfunction

  function automatic void store_bytes(input logic [31:0] addr, input logic [31:0] d,
                                      input int n);
    logic [31:0] a;
    for (int i = 0; i < n; i++) begin
      a = addr + i;
      arch_mem[a % MEM_BYTES] = d[8*i +: 8];
    end
  endfunction

  // execute one word on the shadow state and return its commit
  function automatic commit_t execute_word(input instr_t w);
    commit_t c;
    logic [31:0] a, b, val, npc, ea, v;
    logic [4:0] sh;
    bit wr, take, bad;
    a = arch_regs[w.rs1];
    b = arch_regs[w.rs2];
    npc = arch_pc + 4;
    val = '0;
    wr = 1;
    take = 0;
    bad = 0;
    sh = w.imm[4:0];
    ea = a + w.imm;
    case (w.op)
      rv32x_pkg::OP_ADDI:  val = a + w.imm;
      rv32x_pkg::OP_ANDI:  val = a & w.imm;
      rv32x_pkg::OP_JALR: begin
        val = arch_pc + 4;
        npc = ea & ~32'd1;
      end
      rv32x_pkg::OP_LB: begin
        v = load_bytes(ea, 1);
        val = {{24{v[7]}}, v[7:0]};
      end
      rv32x_pkg::OP_LBU:   val = load_bytes(ea, 1);
      rv32x_pkg::OP_LH: begin
        v = load_bytes(ea, 2);
        val = {{16{v[15]}}, v[15:0]};
      end
      rv32x_pkg::OP_LHU:   val = load_bytes(ea, 2);
      rv32x_pkg::OP_LW:    val = load_bytes(ea, 4);
      rv32x_pkg::OP_ORI:   val = a | w.imm;
      rv32x_pkg::OP_SLLI:  val = a << sh;
      rv32x_pkg::OP_SLTI:  val = ($signed(a) < $signed(w.imm)) ? 32'd1 : 32'd0;
      rv32x_pkg::OP_SLTIU: val = (a < w.imm) ? 32'd1 : 32'd0;
      rv32x_pkg::OP_SRAI:  val = $signed(a) >>> sh;
      rv32x_pkg::OP_SRLI:  val = a >> sh;
      rv32x_pkg::OP_XORI:  val = a ^ w.imm;
      rv32x_pkg::OP_SB: begin
        store_bytes(ea, b, 1);
        wr = 0;
      end
      rv32x_pkg::OP_SH: begin
        store_bytes(ea, b, 2);
        wr = 0;
      end
      rv32x_pkg::OP_SW: begin
        store_bytes(ea, b, 4);
        wr = 0;
      end
      rv32x_pkg::OP_ADD:   val = a + b;
      rv32x_pkg::OP_AND:   val = a & b;
      rv32x_pkg::OP_OR:    val = a | b;
      rv32x_pkg::OP_SLL:   val = a << b[4:0];
      rv32x_pkg::OP_SLT:   val = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
      rv32x_pkg::OP_SLTU:  val = (a < b) ? 32'd1 : 32'd0;
      rv32x_pkg::OP_SRA:   val = $signed(a) >>> b[4:0];
      rv32x_pkg::OP_SRL:   val = a >> b[4:0];
      rv32x_pkg::OP_SUB:   val = a - b;
      rv32x_pkg::OP_XOR:   val = a ^ b;
      rv32x_pkg::OP_BEQ, rv32x_pkg::OP_BGE, rv32x_pkg::OP_BGEU,
      rv32x_pkg::OP_BLT, rv32x_pkg::OP_BLTU, rv32x_pkg::OP_BNE: begin
        wr = 0;
        case (w.op)
          rv32x_pkg::OP_BEQ:  take = (a == b);
          rv32x_pkg::OP_BGE:  take = !($signed(a) < $signed(b));
          rv32x_pkg::OP_BGEU: take = (a >= b);
          rv32x_pkg::OP_BLT:  take = ($signed(a) < $signed(b));
          rv32x_pkg::OP_BLTU: take = (a < b);
          default: take = (a != b);
        endcase
      end
      rv32x_pkg::OP_JAL: begin
        val = arch_pc + 4;
        npc = arch_pc + w.imm;
      end
      rv32x_pkg::OP_AUIPC: val = arch_pc + (w.imm << 12);
      rv32x_pkg::OP_LUI:   val = w.imm << 12;
      default: begin
        wr = 0;
        bad = 1;
      end
    endcase
    if (take) npc = arch_pc + w.imm;
    if (w.rd == 0) wr = 0;
    if (wr) arch_regs[w.rd] = val;
    arch_regs[0] = '0;
    arch_pc = npc;
    c.next_pc = npc;
    c.reg_written = wr;
    c.dest_index = wr ? w.rd : 5'd0;
    c.dest_value = wr ? val : 32'd0;
    c.bad_op = bad;
    return c;
  endfunction

  function automatic void add_word(input logic [5:0] o, input logic [4:0] d,
                                   input logic [4:0] s1, input logic [4:0] s2,
                                   input logic [31:0] i, input bit h = 0);
    instr_t w;
    w.op = o;
    w.rd = d;
    w.rs1 = s1;
    w.rs2 = s2;
    w.imm = i;
    w.hold = h;
    pending_words.push_back(w);
  endfunction

  // idle percentages follow the phase, which rotates every hundred words
  function automatic int sender_idle_pct();
    case ((n_sent / 100) % 4)
      1: return 55;
      3: return 7;
      default: return 0;
    endcase
  endfunction

  function automatic int receiver_stall_pct();
    case ((n_sent / 100) % 4)
      2: return 55;
      3: return 7;
      default: return 0;
    endcase
  endfunction

  // driver: predict on acceptance, then present the next word or idle
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 0;
    end else begin
      bit can_present;
      if (in_valid && !in_stall) begin
        expected_commits.push_back(execute_word(pending_words.pop_front()));
        n_sent++;
      end
      if (!in_valid || !in_stall) begin
        can_present = pending_words.size() > 0
                      && $urandom_range(99) >= sender_idle_pct();
        if (can_present && pending_words[0].hold &&
            (expected_commits.size() > 0 || (in_valid && !in_stall)))
          can_present = 0;
        if (can_present) begin
          in_valid <= 1;
          op <= pending_words[0].op;
          rd <= pending_words[0].rd;
          rs1 <= pending_words[0].rs1;
          rs2 <= pending_words[0].rs2;
          imm <= pending_words[0].imm;
        end else begin
          in_valid <= 0;
        end
      end
    end
  end

  // receiver stall
  always @(posedge clk) begin
    if (rst) out_stall <= 0;
    else out_stall <= $urandom_range(99) < receiver_stall_pct();
  end

  // monitor: compare each accepted commit with the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_commits.size() == 0) begin
        $error("unexpected commit word next_pc=%h", next_pc);
        n_errors++;
      end else begin
        commit_t e;
        e = expected_commits.pop_front();
        if (next_pc !== e.next_pc) begin
          $error("next_pc expected %h actual %h", e.next_pc, next_pc);
          n_errors++;
        end
        if (reg_written !== e.reg_written) begin
          $error("reg_written expected %b actual %b", e.reg_written, reg_written);
          n_errors++;
        end
        if (dest_index !== e.dest_index) begin
          $error("dest_index expected %0d actual %0d", e.dest_index, dest_index);
          n_errors++;
        end
        if (dest_value !== e.dest_value) begin
          $error("dest_value expected %h actual %h", e.dest_value, dest_value);
          n_errors++;
        end
        if (bad_op !== e.bad_op) begin
          $error("bad_op expected %b actual %b", e.bad_op, bad_op);
          n_errors++;
        end
      end
    end
  end

  // stimulus and end of run
  initial begin
    for (int i = 0; i < 32; i++) arch_regs[i] = '0;
    arch_regs[2] = MEM_BYTES;
    arch_pc = '0;
    for (int i = 0; i < MEM_BYTES; i++) arch_mem[i] = '0;

    // directed: extremes, most op families, x0 target, wrap, jalr rd==rs1, invalid ops
    add_word(rv32x_pkg::OP_LUI, 5, 0, 0, 32'h0008_0000);
    add_word(rv32x_pkg::OP_ADDI, 6, 0, 0, 32'hFFFF_FFFF);
    add_word(rv32x_pkg::OP_ADDI, 0, 6, 0, 32'd5);
    add_word(rv32x_pkg::OP_SW, 0, 2, 6, 32'hFFFF_FFFE);
    add_word(rv32x_pkg::OP_SH, 0, 0, 5, 32'd1023);
    add_word(rv32x_pkg::OP_LW, 7, 2, 0, 32'hFFFF_FFFE);
    add_word(rv32x_pkg::OP_LH, 8, 0, 0, 32'd1023);
    add_word(rv32x_pkg::OP_LHU, 9, 0, 0, 32'd1023);
    add_word(rv32x_pkg::OP_SB, 0, 0, 6, 32'h7FFF_FFFF);
    add_word(rv32x_pkg::OP_LB, 10, 0, 0, 32'd1023);
    add_word(rv32x_pkg::OP_LBU, 11, 0, 0, 32'd1023);
    add_word(rv32x_pkg::OP_SRAI, 12, 5, 0, 32'hFFFF_FFFF);
    add_word(rv32x_pkg::OP_SRLI, 13, 5, 0, 32'h8000_003F);
    add_word(rv32x_pkg::OP_SLLI, 14, 6, 0, 32'h0000_0021);
    add_word(rv32x_pkg::OP_SLL, 15, 6, 6, 32'd0);
    add_word(rv32x_pkg::OP_SRA, 16, 5, 6, 32'd0);
    add_word(rv32x_pkg::OP_SRL, 17, 5, 6, 32'd0);
    add_word(rv32x_pkg::OP_SLT, 18, 5, 6, 32'd0);
    add_word(rv32x_pkg::OP_SLTU, 19, 5, 6, 32'd0);
    add_word(rv32x_pkg::OP_SLTI, 20, 6, 0, 32'h8000_0000);
    add_word(rv32x_pkg::OP_SLTIU, 21, 6, 0, 32'h7FFF_FFFF);
    add_word(rv32x_pkg::OP_BLT, 0, 6, 6, 32'd64);
    add_word(rv32x_pkg::OP_BLTU, 0, 5, 5, 32'd64);
    add_word(rv32x_pkg::OP_BGE, 0, 6, 6, 32'hFFFF_FFF0);
    add_word(rv32x_pkg::OP_JALR, 22, 22, 0, 32'd7);
    add_word(6'd37, 3, 1, 1, 32'd0);
    add_word(6'd63, 31, 31, 31, 32'hFFFF_FFFF, 1);

    // random: mostly valid ops with mixed immediates, occasional invalid opcodes
    for (int n = 0; n < N_RANDOM; n++) begin
      logic [5:0] o;
      logic [31:0] i;
      o = ($urandom_range(9) == 0) ? 6'($urandom_range(37, 63)) : 6'($urandom_range(36));
      case ($urandom_range(2))
        0: i = $urandom;
        1: i = 32'($urandom_range(4095)) - 32'd2048;
        default: i = 32'($urandom_range(MEM_BYTES - 1));
      endcase
      add_word(o, 5'($urandom), 5'($urandom), 5'($urandom), i, n == 700);
    end

    repeat (6) @(posedge clk);
    rst <= 0;
    wait (pending_words.size() == 0 && !in_valid);
    wait (expected_commits.size() == 0);
    repeat (20) @(posedge clk);
    if (n_errors == 0 && expected_commits.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end
endmodule
